// ----- hdl/ophp_pkg.sv -----
package ophp_pkg;

   // role of one stream byte
   typedef enum logic [1:0] {
      ROLE_HEADER  = 2'd0,
      ROLE_LENGTH  = 2'd1,
      ROLE_PAYLOAD = 2'd2,
      ROLE_CHUNK   = 2'd3
   } byte_role_type;

   // kind of a completed length
   typedef enum logic [1:0] {
      KIND_FINAL   = 2'd0,
      KIND_PARTIAL = 2'd1,
      KIND_STREAM  = 2'd2
   } length_kind_type;

   // framer phase, one-hot
   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_LENGTH  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   // length byte counter code: second byte of the two-byte new-format length
   localparam logic [2:0] NEW_TWO_PENDING = 3'd5;

   // header byte fields
   localparam logic [7:0] HDR_NEW_BIT     = 8'h40;
   localparam logic [7:0] TAG_FIELD       = 8'h3f;
   localparam logic [7:0] CHUNK_EXP_FIELD = 8'h1f;
   localparam logic [7:0] LTYPE_MASK      = 8'h03;
   localparam logic [1:0] LTYPE_ONE       = 2'd0;
   localparam logic [1:0] LTYPE_TWO       = 2'd1;
   localparam logic [1:0] LTYPE_FOUR      = 2'd2;
   localparam logic [1:0] LTYPE_STREAM    = 2'd3;

   // new-format first length byte thresholds
   localparam logic [7:0] LEN_TWO_BASE  = 8'd192;
   localparam logic [7:0] LEN_PART_BASE = 8'd224;
   localparam logic [7:0] LEN_FIVE      = 8'd255;

   // one result item
   typedef struct packed {
      byte_role_type   byte_role;
      logic [5:0]      packet_tag;
      logic            new_format;
      logic            tag_handled;
      logic            length_done;
      logic [31:0]     body_length;
      length_kind_type length_kind;
      logic            packet_end;
   } rsp_item_type;

   // tags that have a body decoder
   function automatic logic tag_has_decoder(input logic [5:0] tag);
      logic hit;
      hit = (tag <= 6'd14) || ((tag >= 6'd17) && (tag <= 6'd19)) || (tag >= 6'd60);
      return hit;
   endfunction

endpackage

// ----- hdl/ophp_framer.sv -----
module ophp_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   output ophp_pkg::rsp_item_type result
);

   ophp_pkg::phase_type phase_ff, phase_in;
   logic [5:0]  tag_ff, tag_in;
   logic        fmt_new_ff, fmt_new_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  left_ff, left_in;
   logic [31:0] payload_ff, payload_in;
   logic        partial_ff, partial_in;
   logic        stream_ff, stream_in;
   logic        is_chunk_ff, is_chunk_in;

   // completion request from the length decode
   logic        comp_en;
   logic [31:0] comp_len;
   logic        comp_partial;
   logic [31:0] shifted;
   logic [2:0]  left_dec;

   ophp_pkg::byte_role_type   role;
   ophp_pkg::length_kind_type kind;
   logic        done;
   logic [31:0] blen;
   logic        pend;

   assign shifted  = {acc_ff[23:0], data_byte};
   assign left_dec = left_ff - 3'd1;

   // next state and result for the byte in the input register
   always_comb begin
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      fmt_new_in  = fmt_new_ff;
      acc_in      = acc_ff;
      left_in     = left_ff;
      payload_in  = payload_ff;
      partial_in  = partial_ff;
      stream_in   = stream_ff;
      is_chunk_in = is_chunk_ff;
      role        = ophp_pkg::ROLE_PAYLOAD;
      kind        = ophp_pkg::KIND_FINAL;
      done        = 1'b0;
      blen        = 32'd0;
      pend        = 1'b0;
      comp_en     = 1'b0;
      comp_len    = 32'd0;
      comp_partial = 1'b0;

      if (stream_ff) begin
         role = ophp_pkg::ROLE_PAYLOAD;
      end else begin
         unique case (phase_ff)
            ophp_pkg::PH_HEADER: begin
               role        = ophp_pkg::ROLE_HEADER;
               partial_in  = 1'b0;
               is_chunk_in = 1'b0;
               acc_in      = 32'd0;
               left_in     = 3'd0;
               payload_in  = 32'd0;
               if ((data_byte & ophp_pkg::HDR_NEW_BIT) != 8'd0) begin
                  fmt_new_in = 1'b1;
                  tag_in     = data_byte[5:0];
                  phase_in   = ophp_pkg::PH_LENGTH;
               end else begin
                  fmt_new_in = 1'b0;
                  tag_in     = {2'b00, data_byte[5:2]};
                  unique case (data_byte[1:0])
                     ophp_pkg::LTYPE_STREAM: begin
                        stream_in = 1'b1;
                        phase_in  = ophp_pkg::PH_PAYLOAD;
                        done      = 1'b1;
                        kind      = ophp_pkg::KIND_STREAM;
                     end
                     ophp_pkg::LTYPE_ONE: begin
                        left_in  = 3'd1;
                        phase_in = ophp_pkg::PH_LENGTH;
                     end
                     ophp_pkg::LTYPE_TWO: begin
                        left_in  = 3'd2;
                        phase_in = ophp_pkg::PH_LENGTH;
                     end
                     ophp_pkg::LTYPE_FOUR: begin
                        left_in  = 3'd4;
                        phase_in = ophp_pkg::PH_LENGTH;
                     end
                     default: begin
                        left_in  = 3'd4;
                        phase_in = ophp_pkg::PH_LENGTH;
                     end
                  endcase
               end
            end
            ophp_pkg::PH_LENGTH: begin
               role = is_chunk_ff ? ophp_pkg::ROLE_CHUNK : ophp_pkg::ROLE_LENGTH;
               if (!fmt_new_ff || ((left_ff != 3'd0) && (left_ff != ophp_pkg::NEW_TWO_PENDING)))
               begin
                  // counted big-endian length field
                  acc_in  = shifted;
                  left_in = left_dec;
                  if (left_dec == 3'd0) begin
                     comp_en  = 1'b1;
                     comp_len = shifted;
                  end
               end else if (left_ff == ophp_pkg::NEW_TWO_PENDING) begin
                  comp_en  = 1'b1;
                  comp_len = shifted + {24'd0, ophp_pkg::LEN_TWO_BASE};
               end else if (data_byte < ophp_pkg::LEN_TWO_BASE) begin
                  comp_en  = 1'b1;
                  comp_len = {24'd0, data_byte};
               end else if (data_byte < ophp_pkg::LEN_PART_BASE) begin
                  acc_in  = {24'd0, data_byte - ophp_pkg::LEN_TWO_BASE};
                  left_in = ophp_pkg::NEW_TWO_PENDING;
               end else if (data_byte == ophp_pkg::LEN_FIVE) begin
                  acc_in  = 32'd0;
                  left_in = 3'd4;
               end else begin
                  comp_en      = 1'b1;
                  comp_partial = 1'b1;
                  comp_len     = 32'd1 << data_byte[4:0];
               end
            end
            ophp_pkg::PH_PAYLOAD: begin
               role       = ophp_pkg::ROLE_PAYLOAD;
               payload_in = payload_ff - 32'd1;
               if (payload_ff == 32'd1) begin
                  if (partial_ff) begin
                     phase_in    = ophp_pkg::PH_LENGTH;
                     is_chunk_in = 1'b1;
                     left_in     = 3'd0;
                     acc_in      = 32'd0;
                  end else begin
                     pend        = 1'b1;
                     phase_in    = ophp_pkg::PH_HEADER;
                     is_chunk_in = 1'b0;
                  end
               end
            end
            default: begin
               role = ophp_pkg::ROLE_PAYLOAD;
            end
         endcase
      end

      // a length field is complete
      if (comp_en) begin
         done       = 1'b1;
         blen       = comp_len;
         kind       = comp_partial ? ophp_pkg::KIND_PARTIAL : ophp_pkg::KIND_FINAL;
         partial_in = comp_partial;
         acc_in     = 32'd0;
         left_in    = 3'd0;
         if (comp_len == 32'd0) begin
            pend        = 1'b1;
            phase_in    = ophp_pkg::PH_HEADER;
            is_chunk_in = 1'b0;
         end else begin
            payload_in = comp_len;
            phase_in   = ophp_pkg::PH_PAYLOAD;
         end
      end
   end

   // result fields follow the updated packet state
   always_comb begin
      result.byte_role   = role;
      result.packet_tag  = tag_in;
      result.new_format  = fmt_new_in;
      result.tag_handled = ophp_pkg::tag_has_decoder(tag_in);
      result.length_done = done;
      result.body_length = blen;
      result.length_kind = kind;
      result.packet_end  = pend;
   end

   // framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ophp_pkg::PH_HEADER;
         tag_ff      <= 6'd0;
         fmt_new_ff  <= 1'b0;
         acc_ff      <= 32'd0;
         left_ff     <= 3'd0;
         payload_ff  <= 32'd0;
         partial_ff  <= 1'b0;
         stream_ff   <= 1'b0;
         is_chunk_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         tag_ff      <= tag_in;
         fmt_new_ff  <= fmt_new_in;
         acc_ff      <= acc_in;
         left_ff     <= left_in;
         payload_ff  <= payload_in;
         partial_ff  <= partial_in;
         stream_ff   <= stream_in;
         is_chunk_ff <= is_chunk_in;
      end
   end

endmodule

// ----- hdl/ophp_out_stage.sv -----
module ophp_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ophp_pkg::rsp_item_type item,
   output logic                   room,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output ophp_pkg::rsp_item_type rsp_item
);

   logic                   valid_ff;
   ophp_pkg::rsp_item_type item_ff;

   // register can take a result when empty or being drained
   assign room       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

endmodule

// ----- hdl/openpgp_packet_header_parser_core.sv -----
// OpenPGP packet framer: one byte of a binary packet stream per request, one result per byte
// giving its role (header, length, payload, chunk length), the current tag and format, and
// the decoded body or chunk length on the byte that completes it. Throughput is one byte per
// clock while rsp_tready does not hold the result register; a request passes through the
// input register and then the result register, and the framing counters update as the
// result is loaded. After an indeterminate length every further byte is payload until reset.
module openpgp_packet_header_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] packet_tag, [6] new_format, [7] tag_handled, [8] length_done,
   // [40:9] body_length, [42:41] length_kind, [47:43] zero
   output logic [47:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] byte_role
   output logic        rsp_tlast    // packet_end
);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   room;
   logic                   advance;
   ophp_pkg::rsp_item_type result;
   ophp_pkg::rsp_item_type rsp_item;

   // input register moves on when the result register has room
   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   ophp_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   ophp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .item       (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // pack the result request
   assign rsp_tdata = {5'd0, rsp_item.length_kind, rsp_item.body_length, rsp_item.length_done,
                       rsp_item.tag_handled, rsp_item.new_format, rsp_item.packet_tag};
   assign rsp_tuser = rsp_item.byte_role;
   assign rsp_tlast = rsp_item.packet_end;

endmodule
